>>> sv/text_cell_pixel_generator_defines.svh
// ----------------------------------------------------------------------------
// Text cell pixel generator assertion macros
// Shared property shapes for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TEXT_CELL_PIXEL_GENERATOR_DEFINES_SVH
`define TEXT_CELL_PIXEL_GENERATOR_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define TCPG_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tcpg: same-cycle check failed");

// Condition implies consequence in the next cycle.
`define TCPG_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tcpg: next-cycle check failed");

`endif

>>> sv/tcpg_pkg.sv
// ----------------------------------------------------------------------------
// Text cell pixel generator package
// Item types, cell geometry, special glyph codes and the glyph pattern ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpg_pkg;

    // Cell geometry
    localparam logic [4:0] CELL_WIDTH  = 5'd8;
    localparam logic [5:0] CELL_HEIGHT = 6'd12;
    localparam logic [5:0] CELL_HALF   = CELL_HEIGHT >> 1;

    // Special glyph codes
    localparam logic [20:0] HALF_UPPER    = 21'h02580;
    localparam logic [20:0] HALF_LOWER    = 21'h02584;
    localparam logic [20:0] FULL_BLOCK    = 21'h02588;
    localparam logic [20:0] BRAILLE_FIRST = 21'h02800;
    localparam logic [20:0] BRAILLE_LAST  = 21'h028FF;

    // Pattern ROM
    localparam int unsigned ROM_GLYPHS = 25;
    localparam logic [4:0]  BAR_SLOT   = 5'd10;
    localparam logic [4:0]  QMARK_SLOT = 5'd24;

    localparam logic [4:0] ROM_ROWS [ROM_GLYPHS][7] = '{
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h04},
        '{5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00},
        '{5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00},
        '{5'h00, 5'h15, 5'h0E, 5'h1F, 5'h0E, 5'h15, 5'h00},
        '{5'h0A, 5'h1F, 5'h0A, 5'h0A, 5'h1F, 5'h0A, 5'h00},
        '{5'h19, 5'h1A, 5'h04, 5'h08, 5'h16, 5'h06, 5'h00},
        '{5'h0E, 5'h11, 5'h17, 5'h15, 5'h17, 5'h10, 5'h0E},
        '{5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00},
        '{5'h10, 5'h08, 5'h04, 5'h02, 5'h01, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F},
        '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h07, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h00, 5'h00, 5'h1C, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h04, 5'h04, 5'h04, 5'h04, 5'h07, 5'h00, 5'h00},
        '{5'h04, 5'h04, 5'h04, 5'h04, 5'h1C, 5'h00, 5'h00},
        '{5'h04, 5'h04, 5'h07, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h04, 5'h04, 5'h1C, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h00, 5'h00, 5'h1F, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h04, 5'h04, 5'h04, 5'h04, 5'h1F, 5'h00, 5'h00},
        '{5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04}
    };

    // Braille dot bits by [row][column] and dot centers
    localparam logic [7:0] DOT_BITS [4][2] = '{
        '{8'h01, 8'h08}, '{8'h02, 8'h10}, '{8'h04, 8'h20}, '{8'h40, 8'h80}
    };
    localparam logic [4:0] DOT_CX [2] = '{5'd2, 5'd5};
    localparam logic [5:0] DOT_CY [4] = '{6'd1, 6'd4, 6'd7, 6'd10};

    // Color levels
    localparam logic [7:0] LEVEL_FULL = 8'd255;
    localparam logic [7:0] LEVEL_ZERO = 8'd0;

    typedef struct packed {
        logic [20:0] glyph_code;
        logic [3:0]  pixel_x;
        logic [4:0]  pixel_y;
        logic [7:0]  fore_red;
        logic [7:0]  fore_green;
        logic [7:0]  fore_blue;
        logic [7:0]  back_red;
        logic [7:0]  back_green;
        logic [7:0]  back_blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_out_item;

endpackage

`default_nettype wire

>>> sv/tcpg_glyph_lit.sv
// ----------------------------------------------------------------------------
// Glyph pixel decision
// Decides whether one pixel of a cell takes the foreground color.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpg_glyph_lit
    import tcpg_pkg::*;
(
    input  t_in_item i_item,
    output logic     o_lit
);

    // Map a glyph code to its pattern slot; unknown codes get the question mark
    function automatic logic [4:0] rom_slot(input logic [20:0] code);
        logic [4:0] slot;
        unique case (code)
            21'h00020: slot = 5'd0;
            21'h0002E: slot = 5'd1;
            21'h0003A: slot = 5'd2;
            21'h0002D: slot = 5'd3;
            21'h0003D: slot = 5'd4;
            21'h0002B: slot = 5'd5;
            21'h0002A: slot = 5'd6;
            21'h00023: slot = 5'd7;
            21'h00025: slot = 5'd8;
            21'h00040: slot = 5'd9;
            21'h0007C: slot = BAR_SLOT;
            21'h02502: slot = BAR_SLOT;
            21'h0002F: slot = 5'd11;
            21'h0005C: slot = 5'd12;
            21'h0005F: slot = 5'd13;
            21'h02500: slot = 5'd14;
            21'h0250C: slot = 5'd15;
            21'h02510: slot = 5'd16;
            21'h02514: slot = 5'd17;
            21'h02518: slot = 5'd18;
            21'h0251C: slot = 5'd19;
            21'h02524: slot = 5'd20;
            21'h0252C: slot = 5'd21;
            21'h02534: slot = 5'd22;
            21'h0253C: slot = 5'd23;
            default:   slot = QMARK_SLOT;
        endcase
        return slot;
    endfunction

    // Stretch columns 1..6 onto the five pattern columns
    function automatic logic [2:0] col_scale(input logic [3:0] x);
        logic [2:0] sx;
        case (x)
            4'd3:    sx = 3'd1;
            4'd4:    sx = 3'd2;
            4'd5:    sx = 3'd3;
            4'd6:    sx = 3'd4;
            default: sx = 3'd0;
        endcase
        return sx;
    endfunction

    // Stretch rows 2..9 onto the seven pattern rows
    function automatic logic [2:0] row_scale(input logic [4:0] y);
        logic [2:0] sy;
        case (y)
            5'd4:    sy = 3'd1;
            5'd5:    sy = 3'd2;
            5'd6:    sy = 3'd3;
            5'd7:    sy = 3'd4;
            5'd8:    sy = 3'd5;
            5'd9:    sy = 3'd6;
            default: sy = 3'd0;
        endcase
        return sy;
    endfunction

    logic       in_cell;
    logic       is_braille;
    logic       braille_lit;
    logic       rom_lit;
    logic       rom_area;
    logic [4:0] slot;
    logic [4:0] rom_row;
    logic [2:0] sx;
    logic [4:0] x5;
    logic [5:0] y6;

    assign x5 = {1'b0, i_item.pixel_x};
    assign y6 = {1'b0, i_item.pixel_y};
    assign in_cell = (x5 < CELL_WIDTH) && (y6 < CELL_HEIGHT);
    assign is_braille = (i_item.glyph_code >= BRAILLE_FIRST)
                     && (i_item.glyph_code <= BRAILLE_LAST);

    // Light a 3x3 square around each set braille dot
    always_comb begin
        braille_lit = 1'b0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 2; c++) begin
                if (((i_item.glyph_code[7:0] & DOT_BITS[r][c]) != 8'd0)
                    && (x5 + 5'd1 >= DOT_CX[c]) && (x5 <= DOT_CX[c] + 5'd1)
                    && (y6 + 6'd1 >= DOT_CY[r]) && (y6 <= DOT_CY[r] + 6'd1)) begin
                    braille_lit = 1'b1;
                end
            end
        end
    end

    // Look up the stretched pattern bit
    assign rom_area = (i_item.pixel_x >= 4'd1) && (i_item.pixel_x <= 4'd6)
                   && (i_item.pixel_y >= 5'd2) && (i_item.pixel_y <= 5'd9);
    assign slot    = rom_slot(i_item.glyph_code);
    assign rom_row = ROM_ROWS[slot][row_scale(i_item.pixel_y)];
    assign sx      = col_scale(i_item.pixel_x);
    assign rom_lit = rom_area && rom_row[3'd4 - sx];

    // Pick the drawing rule for the glyph
    always_comb begin
        o_lit = 1'b0;
        if (in_cell) begin
            if (i_item.glyph_code == HALF_UPPER) begin
                o_lit = y6 < CELL_HALF;
            end else if (i_item.glyph_code == HALF_LOWER) begin
                o_lit = y6 >= CELL_HALF;
            end else if (i_item.glyph_code == FULL_BLOCK) begin
                o_lit = 1'b1;
            end else if (is_braille) begin
                o_lit = braille_lit;
            end else begin
                o_lit = rom_lit;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/text_cell_pixel_generator.sv
// ----------------------------------------------------------------------------
// Text cell pixel generator
// Colors one pixel of a terminal character cell from its glyph and position.
// ----------------------------------------------------------------------------
//  Channel  | Signals                        | Moves
//  ---------+--------------------------------+------------------------------
//  in       | i_in_valid, o_in_stall, data   | glyph, position, two colors
//  out      | o_out_valid, i_out_stall, data | pixel color
//  cfg      | i_cfg_we, i_cfg_data           | mono mode bit
//
// One item per cycle sustained while the output is not stalled. An accepted
// item passes the input register, then the result register, which drives
// o_out_valid. The glyph decode between the two registers sets the clock
// period.
// Reset clears both valid flags and mono mode; no clearing pass.
// An output stall holds the result; the input register still fills, then
// o_in_stall rises only while both registers hold items.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_cell_pixel_generator_defines.svh"

module text_cell_pixel_generator
    import tcpg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data
);

    logic      r_mono;
    logic      r_mid_valid;
    t_in_item  r_mid;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      lit;
    logic      out_free;
    logic      mid_adv;
    logic      in_acc;
    logic      mono_ok;
    logic [7:0] fg_r, fg_g, fg_b, bg_r, bg_g, bg_b;

    // Handshake control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign mid_adv    = r_mid_valid && out_free;
    assign o_in_stall = r_mid_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Decide the pixel
    tcpg_glyph_lit u_glyph_lit (
        .i_item (r_mid),
        .o_lit  (lit)
    );

    // Apply mono mode and select the color
    assign fg_r = r_mono ? LEVEL_FULL : r_mid.fore_red;
    assign fg_g = r_mono ? LEVEL_FULL : r_mid.fore_green;
    assign fg_b = r_mono ? LEVEL_FULL : r_mid.fore_blue;
    assign bg_r = r_mono ? LEVEL_ZERO : r_mid.back_red;
    assign bg_g = r_mono ? LEVEL_ZERO : r_mid.back_green;
    assign bg_b = r_mono ? LEVEL_ZERO : r_mid.back_blue;

    assign n_out.out_red   = lit ? fg_r : bg_r;
    assign n_out.out_green = lit ? fg_g : bg_g;
    assign n_out.out_blue  = lit ? fg_b : bg_b;

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono      <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mono <= i_cfg_data;
            end
            if (in_acc) begin
                r_mid_valid <= 1'b1;
            end else if (mid_adv) begin
                r_mid_valid <= 1'b0;
            end
            if (mid_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mid <= i_in_data;
        end
        if (mid_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Mono colors are full or zero and equal on all three components
    assign mono_ok = (n_out.out_red == n_out.out_green)
                  && (n_out.out_green == n_out.out_blue)
                  && ((n_out.out_red == LEVEL_FULL) || (n_out.out_red == LEVEL_ZERO));

    // Checks
    `TCPG_ASSERT_NOW(a_stall_means_full, i_clk, i_rst_n, o_in_stall, r_mid_valid && r_out_valid)
    `TCPG_ASSERT_NEXT(a_accept_fills_mid, i_clk, i_rst_n, in_acc, r_mid_valid)
    `TCPG_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, mid_adv, r_out_valid)
    `TCPG_ASSERT_NOW(a_mono_levels, i_clk, i_rst_n, r_mid_valid && r_mono, mono_ok)

endmodule

`default_nettype wire

>>> tb/text_cell_pixel_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text cell pixel generator testbench
// Streams glyph/position/color items through the block with random sender
// bursts and receiver stalls, predicts each pixel color from a local glyph
// model, and compares every result in order. Runs with mono mode off and on.
// ----------------------------------------------------------------------------

module text_cell_pixel_generator_tb;
    import tcpg_pkg::*;

    // Local cell geometry and glyph tables
    localparam int CELL_W = CELL_WIDTH;
    localparam int CELL_H = CELL_HEIGHT;
    localparam int GLYPH_COUNT = 25;
    localparam int BAR_ENTRY = 10;
    localparam int QMARK_ENTRY = 24;
    localparam logic [20:0] BOX_VERTICAL = 21'h02502;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [20:0] GLYPH_CODES [GLYPH_COUNT] = '{
        21'h20, 21'h2E, 21'h3A, 21'h2D, 21'h3D, 21'h2B, 21'h2A, 21'h23, 21'h25,
        21'h40, 21'h7C, 21'h2F, 21'h5C, 21'h5F, 21'h2500, 21'h250C, 21'h2510,
        21'h2514, 21'h2518, 21'h251C, 21'h2524, 21'h252C, 21'h2534, 21'h253C,
        21'h3F
    };

    localparam logic [4:0] GLYPH_ROWS [GLYPH_COUNT][7] = '{
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h04},
        '{5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00},
        '{5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00},
        '{5'h00, 5'h15, 5'h0E, 5'h1F, 5'h0E, 5'h15, 5'h00},
        '{5'h0A, 5'h1F, 5'h0A, 5'h0A, 5'h1F, 5'h0A, 5'h00},
        '{5'h19, 5'h1A, 5'h04, 5'h08, 5'h16, 5'h06, 5'h00},
        '{5'h0E, 5'h11, 5'h17, 5'h15, 5'h17, 5'h10, 5'h0E},
        '{5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00},
        '{5'h10, 5'h08, 5'h04, 5'h02, 5'h01, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F},
        '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h07, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h00, 5'h00, 5'h1C, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h04, 5'h04, 5'h04, 5'h04, 5'h07, 5'h00, 5'h00},
        '{5'h04, 5'h04, 5'h04, 5'h04, 5'h1C, 5'h00, 5'h00},
        '{5'h04, 5'h04, 5'h07, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h04, 5'h04, 5'h1C, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h00, 5'h00, 5'h1F, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h04, 5'h04, 5'h04, 5'h04, 5'h1F, 5'h00, 5'h00},
        '{5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04}
    };

    // Braille dot bit index by [row][column], and dot centers
    localparam int DOT_BIT [4][2] = '{'{0, 3}, '{1, 4}, '{2, 5}, '{6, 7}};
    localparam int DOT_X [2] = '{2, 5};
    localparam int DOT_Y [4] = '{1, 4, 7, 10};

    // Codes just next to the special ranges, and 21'h10FFFF
    localparam logic [20:0] EDGE_CODES [6] = '{
        BRAILLE_FIRST - 21'd1, BRAILLE_LAST + 21'd1, HALF_UPPER + 21'd1,
        HALF_LOWER - 21'd1, FULL_BLOCK + 21'd1, 21'h10FFFF
    };

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PULSE
    } t_stall_mode;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;
    logic      cfg_we = 1'b0;
    logic      cfg_data = 1'b0;

    t_in_item    pending_pixels [$];
    t_out_item   expected_pixels [$];
    bit          mono_setting = 1'b0;
    logic        in_taken = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_run = 0;
    int          idle_cycles = 0;
    int          pixels_sent = 0;
    int          results_checked = 0;
    int          mismatch_count = 0;
    int          phase_count = 0;

    text_cell_pixel_generator uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Predict the color of one pixel for the given mono setting
    function automatic t_out_item shade_pixel(t_in_item px, bit mono);
        t_out_item   fore;
        t_out_item   back;
        logic        lit;
        logic [20:0] code;
        int          x, y, slot, sx, sy, r, c, i;
        fore = mono ? {3{8'hFF}} : {px.fore_red, px.fore_green, px.fore_blue};
        back = mono ? {3{8'h00}} : {px.back_red, px.back_green, px.back_blue};
        code = px.glyph_code;
        x = int'(px.pixel_x);
        y = int'(px.pixel_y);
        lit = 1'b0;
        if (x < CELL_W && y < CELL_H) begin
            if (code == HALF_UPPER) begin
                lit = (y < CELL_H / 2);
            end else if (code == HALF_LOWER) begin
                lit = (y >= CELL_H / 2);
            end else if (code == FULL_BLOCK) begin
                lit = 1'b1;
            end else if (code >= BRAILLE_FIRST && code <= BRAILLE_LAST) begin
                // light a 3x3 square around each set dot; the low byte is the dot mask
                for (r = 0; r < 4; r++)
                    for (c = 0; c < 2; c++)
                        if (code[DOT_BIT[r][c]] && x - DOT_X[c] <= 1 && DOT_X[c] - x <= 1 &&
                            y - DOT_Y[r] <= 1 && DOT_Y[r] - y <= 1)
                            lit = 1'b1;
            end else if (x >= 1 && x <= 6 && y >= 2 && y <= 9) begin
                // stretch the 5x7 pattern over columns 1..6 and rows 2..9
                slot = QMARK_ENTRY;
                if (code == BOX_VERTICAL) begin
                    slot = BAR_ENTRY;
                end else begin
                    for (i = 0; i < GLYPH_COUNT; i++)
                        if (GLYPH_CODES[i] == code)
                            slot = i;
                end
                sx = (x - 1) * 5 / 6;
                sy = (y - 2) * 7 / 8;
                lit = GLYPH_ROWS[slot][sy][4 - sx];
            end
        end
        return lit ? fore : back;
    endfunction

    task automatic queue_pixel(logic [20:0] code, int x, int y, logic [23:0] fg,
                               logic [23:0] bg);
        t_in_item item;
        item.glyph_code = code;
        item.pixel_x = 4'(x);
        item.pixel_y = 5'(y);
        {item.fore_red, item.fore_green, item.fore_blue} = fg;
        {item.back_red, item.back_green, item.back_blue} = bg;
        pending_pixels.push_back(item);
    endtask

    // Queue random pixels, weighted toward glyphs the block draws specially
    task automatic queue_random_pixels(int count);
        logic [20:0] code;
        int          x, y, n;
        for (n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0, 1:    code = GLYPH_CODES[$urandom_range(0, GLYPH_COUNT - 1)];
                2:       code = ($urandom_range(0, 3) == 0) ? BOX_VERTICAL :
                                GLYPH_CODES[$urandom_range(0, GLYPH_COUNT - 1)];
                3: begin
                    case ($urandom_range(0, 2))
                        0:       code = HALF_UPPER;
                        1:       code = HALF_LOWER;
                        default: code = FULL_BLOCK;
                    endcase
                end
                4, 5, 6: code = BRAILLE_FIRST + 21'($urandom_range(0, 255));
                7:       code = 21'($urandom_range(0, 21'h10FFFF));
                8:       code = 21'($urandom());
                default: code = EDGE_CODES[$urandom_range(0, 5)];
            endcase
            x = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) :
                $urandom_range(0, CELL_W - 1);
            y = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) :
                $urandom_range(0, CELL_H - 1);
            queue_pixel(code, x, y, 24'($urandom()), 24'($urandom()));
        end
    endtask

    // Hold until the sender is empty and every expected result has come
    task automatic wait_drained();
        @(posedge clk);
        while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mono(bit value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        mono_setting = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        phase_count++;
    endtask

    // Sender: bursts of items with random gaps between them
    always @(negedge clk) begin
        if (!in_valid || in_taken) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
                in_data <= pending_pixels.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern that changes mode after each random-length run
    always @(negedge clk) begin
        if (stall_run == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_run <= $urandom_range(8, 40);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= stall_run[1];
        endcase
    end

    // Record accepted items and check accepted results in order
    always @(posedge clk) begin
        t_out_item want;
        in_taken <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall) begin
            expected_pixels.push_back(shade_pixel(in_data, mono_setting));
            pixels_sent++;
        end
        if (rst_n && out_valid && !out_stall) begin
            if (expected_pixels.size() == 0) begin
                $error("pixel result with no item waiting: %h", out_data);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                results_checked++;
                if (out_data.out_red !== want.out_red) begin
                    $error("out_red expected %0d actual %0d", want.out_red, out_data.out_red);
                    mismatch_count++;
                end
                if (out_data.out_green !== want.out_green) begin
                    $error("out_green expected %0d actual %0d", want.out_green,
                           out_data.out_green);
                    mismatch_count++;
                end
                if (out_data.out_blue !== want.out_blue) begin
                    $error("out_blue expected %0d actual %0d", want.out_blue,
                           out_data.out_blue);
                    mismatch_count++;
                end
            end
        end
    end

    // Drop the run if nothing moves on either channel for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Mono off: directed corners, then random
        write_mono(1'b0);
        queue_pixel(21'h000000, 0, 0, 24'hFFFFFF, 24'h000000);
        queue_pixel(21'h1FFFFF, 15, 31, 24'h000000, 24'hFFFFFF);
        queue_pixel(21'h110000, 3, 2, 24'hFF00FF, 24'h00FF00);
        queue_pixel(21'h10FFFF, 5, 9, 24'h123456, 24'hABCDEF);
        queue_pixel(HALF_UPPER, 0, CELL_H / 2 - 1, 24'hFFFFFF, 24'h000000);
        queue_pixel(HALF_UPPER, 7, CELL_H / 2, 24'hFFFFFF, 24'h000000);
        queue_pixel(HALF_LOWER, 0, CELL_H / 2, 24'h0000FF, 24'hFF0000);
        queue_pixel(HALF_LOWER, 7, CELL_H / 2 - 1, 24'h0000FF, 24'hFF0000);
        queue_pixel(FULL_BLOCK, CELL_W - 1, CELL_H - 1, 24'hA5A5A5, 24'h5A5A5A);
        queue_pixel(FULL_BLOCK, CELL_W, 0, 24'hA5A5A5, 24'h5A5A5A);
        queue_pixel(FULL_BLOCK, 0, CELL_H, 24'hA5A5A5, 24'h5A5A5A);
        queue_pixel(BRAILLE_LAST, 1, 0, 24'hFFFFFF, 24'h000000);
        queue_pixel(BRAILLE_LAST, 6, CELL_H - 1, 24'hFFFFFF, 24'h000000);
        queue_pixel(BRAILLE_FIRST, 2, 1, 24'hFFFFFF, 24'h000000);
        queue_pixel(BRAILLE_FIRST + 21'h80, 6, 11, 24'h00FFFF, 24'h800000);
        queue_pixel(BRAILLE_FIRST + 21'h01, 3, 2, 24'h00FFFF, 24'h800000);
        queue_pixel(BRAILLE_FIRST + 21'h01, 4, 1, 24'h00FFFF, 24'h800000);
        queue_pixel(BOX_VERTICAL, 4, 5, 24'hFFFF00, 24'h0000FF);
        queue_pixel(21'h40, 1, 2, 24'hFFFF00, 24'h0000FF);
        queue_pixel(21'h2F, 6, 9, 24'hFFFF00, 24'h0000FF);
        queue_pixel(21'h20, 4, 5, 24'hFFFF00, 24'h0000FF);
        queue_pixel(21'h253C, 0, 5, 24'hFFFF00, 24'h0000FF);
        queue_pixel(21'h3F, 4, 10, 24'hFFFF00, 24'h0000FF);
        queue_random_pixels(150);
        wait_drained();

        // Alternate mono mode, letting the block drain before each write
        write_mono(1'b1);
        queue_random_pixels(130);
        wait_drained();
        write_mono(1'b0);
        queue_random_pixels(140);
        wait_drained();
        write_mono(1'b1);
        queue_random_pixels(130);
        wait_drained();
        repeat (4) @(posedge clk);

        $display("Checked %0d pixel results from %0d items over %0d mono phases,",
                 results_checked, pixels_sent, phase_count);
        $display("covering half/full blocks, braille, pattern glyphs and off-cell pixels.");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/tcpg_pkg.sv
sv/tcpg_glyph_lit.sv
sv/text_cell_pixel_generator.sv
tb/text_cell_pixel_generator_tb.sv
